[hdl/sliding_window_statistics_top_defines.svh]
// Assertion macros for the sliding window statistics block.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef SLIDING_WINDOW_STATISTICS_TOP_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SWS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window statistics: check failed");
// next-cycle implication
`define SWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window statistics: check failed");
`else
`define SWS_ASSERT_IMPL(label, ante, cons)
`define SWS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/swstat_pkg.sv]
// Shared types and constants for the sliding window statistics block.
// No dependencies.
package swstat_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CNT_W      = 11;
    localparam int RATIO_W    = 17;
    localparam int SUM_W      = SAMPLE_W + CNT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // ring depth; the count fields are sized for it
    localparam int MAX_WINDOW = 1024;

    localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'd65536;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd32768;
    localparam logic [CNT_W-1:0]   LEN_RESET   = 11'd1024;

    // action codes
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENTILE_RATIO = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] last_value;
        logic signed [SAMPLE_W-1:0] window_min;
        logic signed [SAMPLE_W-1:0] window_max;
        logic signed [SAMPLE_W-1:0] window_mean;
        logic signed [SAMPLE_W-1:0] percentile_value;
        logic        [CNT_W-1:0]    sample_count;
    } out_item_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hdl/swstat_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on swstat_pkg.
module swstat_div (
    input  logic                clk,
    input  logic                rst_n,
    input  swstat_pkg::div_req_t req,
    output swstat_pkg::div_rsp_t rsp
);
    import swstat_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0] dvd_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] dvs_reg;

    logic [CNT_W:0]   trial;
    logic             qbit;
    logic [CNT_W:0]   rem_next;

    // trial subtract
    always_comb
    begin
        trial = {rem_reg, dvd_reg[SUM_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        rem_next = qbit ? (trial - {1'b0, dvs_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
            dvd_reg  <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next[CNT_W-1:0];
            dvd_reg  <= {dvd_reg[SUM_W-2:0], qbit};
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

[hdl/swstat_core.sv]
// Ring store, eviction and order-statistic sequencer.
// Depends on swstat_pkg and swstat_div.
module swstat_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  swstat_pkg::in_item_t          item,
    input  logic [swstat_pkg::CNT_W-1:0]   window_length,
    input  logic [swstat_pkg::RATIO_W-1:0] percentile_ratio,
    output logic                          idle,
    output logic                          result_valid,
    input  logic                          result_take,
    output swstat_pkg::out_item_t         result
);
    import swstat_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [CNT_W:0] MAX_W = (CNT_W+1)'(MAX_WINDOW);
    localparam logic [SAMPLE_W-1:0] SIGN_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EVICT   = 3'd1;
    localparam logic [2:0] S_EVSUB   = 3'd2;
    localparam logic [2:0] S_PREP    = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_DIVWAIT = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]                state_reg;
    logic [AW-1:0]             ws_reg;
    logic [CNT_W-1:0]          held_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SAMPLE_W-1:0]       last_reg;
    logic [SAMPLE_W-1:0]       smp_reg;
    logic [CNT_W-1:0]          len_reg;
    logic [AW-1:0]             addr_reg;
    logic [AW-1:0]             start_reg;
    logic [CNT_W-1:0]          issued_reg;
    logic                      rd_pend_reg;
    logic [SAMPLE_W-1:0]       rd_data_reg;
    logic [SAMPLE_W-1:0]       mask_reg;
    logic [SAMPLE_W-1:0]       bit_reg;
    logic [SAMPLE_W-1:0]       pfx_reg  [3];
    logic [CNT_W-1:0]          rank_reg [3];
    logic [CNT_W-1:0]          cnt_reg  [3];
    logic                      neg_reg;
    logic                      div_start_reg;
    out_item_t                 result_reg;

    logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

    logic [CNT_W-1:0]    len_eff;
    logic [CNT_W:0]      old_tmp;
    logic [AW-1:0]       oldest;
    logic [AW-1:0]       addr_inc;
    logic [AW-1:0]       ws_inc;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [RATIO_W-1:0]  ratio_c;
    logic [RATIO_W+CNT_W:0] k_prod;
    logic [CNT_W-1:0]    k_raw;
    logic [CNT_W-1:0]    k_val;
    logic [SAMPLE_W-1:0] x_biased;
    logic [SUM_W-1:0]    sum_mag;
    logic [SUM_W-1:0]    mean_full;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // effective window length
    always_comb
    begin
        if (window_length == '0)
            len_eff = CNT_W'(1);
        else if ({1'b0, window_length} > MAX_W)
            len_eff = MAX_W[CNT_W-1:0];
        else
            len_eff = window_length;
    end

    // oldest held slot and pointer increments with wrap
    always_comb
    begin
        old_tmp = (CNT_W+1)'(ws_reg) + MAX_W - {1'b0, held_reg};
        if (old_tmp >= MAX_W)
            old_tmp = old_tmp - MAX_W;
        oldest   = AW'(old_tmp);
        addr_inc = ((CNT_W+1)'(addr_reg) == MAX_W - 1'b1) ? '0 : addr_reg + 1'b1;
        ws_inc   = ((CNT_W+1)'(ws_reg) == MAX_W - 1'b1) ? '0 : ws_reg + 1'b1;
    end

    // percentile rank, mean magnitude and sign, biased read data
    always_comb
    begin
        ratio_c = (percentile_ratio > RATIO_ONE) ? RATIO_ONE : percentile_ratio;
        k_prod  = (RATIO_W+CNT_W+1)'(ratio_c) * (RATIO_W+CNT_W+1)'(held_reg - 1'b1)
                  + (RATIO_W+CNT_W+1)'(32768);
        k_raw   = k_prod[16 +: CNT_W];
        k_val   = (k_raw > held_reg - 1'b1) ? held_reg - 1'b1 : k_raw;
        sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mean_full = neg_reg ? -div_rsp.quotient : div_rsp.quotient;
        x_biased  = rd_data_reg ^ SIGN_BIT;
    end

    assign mem_raddr = (state_reg == S_SCAN) ? addr_reg : oldest;
    assign mem_we    = (state_reg == S_EVICT) && !((held_reg >= len_reg) && (held_reg != '0));

    // ring store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[ws_reg] <= smp_reg;
        rd_data_reg <= ring_mem[mem_raddr];
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = sum_mag;
    assign div_req.divisor  = held_reg;

    swstat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
            smp_reg       <= '0;
            len_reg       <= '0;
            addr_reg      <= '0;
            start_reg     <= '0;
            issued_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            mask_reg      <= '0;
            bit_reg       <= '0;
            neg_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            result_reg    <= '0;
            for (int j = 0; j < 3; j++)
            begin
                pfx_reg[j]  <= '0;
                rank_reg[j] <= '0;
                cnt_reg[j]  <= '0;
            end
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (item.action == ACT_CLEAR)
                        begin
                            ws_reg     <= '0;
                            held_reg   <= '0;
                            sum_reg    <= '0;
                            last_reg   <= '0;
                            result_reg <= '0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            smp_reg   <= item.sample;
                            len_reg   <= len_eff;
                            state_reg <= S_EVICT;
                        end
                    end
                end
                S_EVICT:
                begin
                    if ((held_reg >= len_reg) && (held_reg != '0))
                        state_reg <= S_EVSUB;
                    else
                    begin
                        ws_reg    <= ws_inc;
                        held_reg  <= held_reg + 1'b1;
                        sum_reg   <= sum_reg + {{CNT_W{smp_reg[SAMPLE_W-1]}}, smp_reg};
                        last_reg  <= smp_reg;
                        state_reg <= S_PREP;
                    end
                end
                S_EVSUB:
                begin
                    // drop the oldest sample
                    sum_reg   <= sum_reg - {{CNT_W{rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
                    held_reg  <= held_reg - 1'b1;
                    state_reg <= S_EVICT;
                end
                S_PREP:
                begin
                    // targets: minimum, maximum, percentile
                    rank_reg[0]   <= '0;
                    rank_reg[1]   <= held_reg - 1'b1;
                    rank_reg[2]   <= k_val;
                    for (int j = 0; j < 3; j++)
                    begin
                        pfx_reg[j] <= '0;
                        cnt_reg[j] <= '0;
                    end
                    mask_reg      <= '0;
                    bit_reg       <= SIGN_BIT;
                    addr_reg      <= oldest;
                    start_reg     <= oldest;
                    issued_reg    <= '0;
                    rd_pend_reg   <= 1'b0;
                    neg_reg       <= sum_reg[SUM_W-1];
                    div_start_reg <= 1'b1;
                    state_reg     <= S_SCAN;
                end
                S_SCAN:
                begin
                    // issue reads over the window
                    if (issued_reg < held_reg)
                    begin
                        addr_reg    <= addr_inc;
                        issued_reg  <= issued_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else
                        rd_pend_reg <= 1'b0;

                    // count samples under each prefix with a zero at this bit
                    if (rd_pend_reg)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            if (((x_biased & mask_reg) == (pfx_reg[j] & mask_reg))
                                && ((x_biased & bit_reg) == '0))
                                cnt_reg[j] <= cnt_reg[j] + 1'b1;
                        end
                    end

                    // end of pass: fix one result bit per target
                    if ((issued_reg == held_reg) && !rd_pend_reg)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            if (rank_reg[j] >= cnt_reg[j])
                            begin
                                pfx_reg[j]  <= pfx_reg[j] | bit_reg;
                                rank_reg[j] <= rank_reg[j] - cnt_reg[j];
                            end
                            cnt_reg[j] <= '0;
                        end
                        if (bit_reg[0])
                            state_reg <= S_DIVWAIT;
                        else
                        begin
                            bit_reg    <= bit_reg >> 1;
                            mask_reg   <= {1'b1, mask_reg[SAMPLE_W-1:1]};
                            issued_reg <= '0;
                            addr_reg   <= start_reg;
                        end
                    end
                end
                S_DIVWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg.last_value       <= last_reg;
                        result_reg.window_min       <= pfx_reg[0] ^ SIGN_BIT;
                        result_reg.window_max       <= pfx_reg[1] ^ SIGN_BIT;
                        result_reg.percentile_value <= pfx_reg[2] ^ SIGN_BIT;
                        result_reg.window_mean      <= mean_full[SAMPLE_W-1:0];
                        result_reg.sample_count     <= held_reg;
                        state_reg                   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (result_take)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle         = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign result       = result_reg;

endmodule

[hdl/sliding_window_statistics_top.sv]
// Sliding window statistics: each push is worked on to the end before the next item is
// accepted. The pace is set by the single ring read port, which is walked once per bit
// of the three order statistics (minimum, maximum, percentile found together by bitwise
// selection); the mean divider runs alongside. The input is stalled while an item is
// being worked on and while its result waits in the core to be taken; a taken result
// waits in the output register.
// Depends on swstat_pkg, swstat_core and sliding_window_statistics_top_defines.svh.
`include "sliding_window_statistics_top_defines.svh"

module sliding_window_statistics_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  swstat_pkg::in_item_t              in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output swstat_pkg::out_item_t             out_item,
    input  logic                              cfg_we,
    input  logic [swstat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swstat_pkg::CFG_DATA_W-1:0] cfg_data
);
    import swstat_pkg::*;

    logic [CNT_W-1:0]   wlen_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               core_idle;
    logic               res_valid;
    logic               res_take;
    out_item_t          res_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= LEN_RESET;
            ratio_reg <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH:    wlen_reg  <= cfg_data[CNT_W-1:0];
                CFG_PERCENTILE_RATIO: ratio_reg <= cfg_data[RATIO_W-1:0];
                default:              ;
            endcase
        end
    end

    assign in_stall = !core_idle;
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    swstat_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (in_valid && !in_stall),
        .item             (in_item),
        .window_length    (wlen_reg),
        .percentile_ratio (ratio_reg),
        .idle             (core_idle),
        .result_valid     (res_valid),
        .result_take      (res_take),
        .result           (res_item)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= res_item;
        end
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // checks
    `SWS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `SWS_ASSERT_IMPL(a_empty_zero, out_valid && (out_item.sample_count == '0),
        (out_item.window_min == '0) && (out_item.window_max == '0)
        && (out_item.window_mean == '0) && (out_item.percentile_value == '0))
    `SWS_ASSERT_IMPL(a_min_le_max, out_valid && (out_item.sample_count != '0),
        (out_item.window_min <= out_item.window_max)
        && (out_item.window_min <= out_item.percentile_value)
        && (out_item.percentile_value <= out_item.window_max))
    `SWS_ASSERT_IMPL(a_count_bound, out_valid,
        {1'b0, out_item.sample_count} <= (CNT_W+1)'(MAX_WINDOW))

endmodule

[tb/sliding_window_statistics_checker.sv]
// Checker for the sliding window statistics block: watches the item and configuration
// channels, keeps its own window model and compares every result item.
// Depends on swstat_pkg.
`timescale 1ns / 100ps

module sliding_window_statistics_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  swstat_pkg::in_item_t              in_item,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  swstat_pkg::out_item_t             out_item,
    input  logic                              cfg_we,
    input  logic [swstat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swstat_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                pending,
    output int                                errors
);
    import swstat_pkg::*;

    // model state
    logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sorted [MAX_WINDOW];
    int unsigned                slot;
    int unsigned                held;
    longint                     sum;
    logic signed [SAMPLE_W-1:0] last;
    logic [CNT_W-1:0]           len_reg;
    logic [RATIO_W-1:0]         ratio_reg;
    out_item_t                  stats_q [$];

    assign pending = stats_q.size();

    task automatic report(input string field, input longint got, input longint want);
        begin
            $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
            errors++;
        end
    endtask

    // update the window with one item and queue the statistics it gives
    task automatic predict_stats(input in_item_t it);
        int unsigned                len;
        int unsigned                oldest;
        int unsigned                start;
        int unsigned                i;
        int unsigned                j;
        longint unsigned            ratio;
        longint unsigned            k;
        logic signed [SAMPLE_W-1:0] v;
        out_item_t                  res;
        begin
            if (it.action == ACT_CLEAR) begin
                slot = 0;
                held = 0;
                sum  = 0;
                last = '0;
            end else begin
                len = (len_reg == 0) ? 1 : (len_reg > MAX_WINDOW) ? MAX_WINDOW : len_reg;
                while (held >= len && held > 0) begin
                    oldest = (slot + MAX_WINDOW - held) % MAX_WINDOW;
                    sum -= longint'(ring[oldest]);
                    held--;
                end
                ring[slot] = it.sample;
                slot = (slot + 1) % MAX_WINDOW;
                held++;
                sum += longint'(it.sample);
                last = it.sample;
            end
            res = '0;
            res.last_value   = last;
            res.sample_count = CNT_W'(held);
            if (held > 0) begin
                start = (slot + MAX_WINDOW - held) % MAX_WINDOW;
                // insertion sort of the held samples, oldest first
                for (i = 0; i < held; i++) begin
                    v = ring[(start + i) % MAX_WINDOW];
                    j = i;
                    while (j > 0 && sorted[j-1] > v) begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = v;
                end
                ratio = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;
                k = (ratio * (held - 1) + 32768) >> 16;
                if (k > held - 1)
                    k = held - 1;
                res.window_min       = sorted[0];
                res.window_max       = sorted[held-1];
                res.percentile_value = sorted[k];
                res.window_mean      = SAMPLE_W'(sum / longint'(held));
            end
            stats_q.push_back(res);
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            slot      = 0;
            held      = 0;
            sum       = 0;
            last      = '0;
            len_reg   = LEN_RESET;
            ratio_reg = RATIO_RESET;
            errors    = 0;
            stats_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_WINDOW_LENGTH)
                    len_reg = cfg_data[CNT_W-1:0];
                else if (cfg_index == CFG_PERCENTILE_RATIO)
                    ratio_reg = cfg_data[RATIO_W-1:0];
            end
            if (out_valid && !out_stall) begin
                if (stats_q.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    errors++;
                end else begin
                    // oldest prediction first
                    want = stats_q[0];
                    stats_q.delete(0);
                    if (out_item.last_value !== want.last_value)
                        report("last_value", out_item.last_value, want.last_value);
                    if (out_item.window_min !== want.window_min)
                        report("window_min", out_item.window_min, want.window_min);
                    if (out_item.window_max !== want.window_max)
                        report("window_max", out_item.window_max, want.window_max);
                    if (out_item.window_mean !== want.window_mean)
                        report("window_mean", out_item.window_mean, want.window_mean);
                    if (out_item.percentile_value !== want.percentile_value)
                        report("percentile_value", out_item.percentile_value,
                               want.percentile_value);
                    if (out_item.sample_count !== want.sample_count)
                        report("sample_count", out_item.sample_count, want.sample_count);
                end
            end
            if (in_valid && !in_stall)
                predict_stats(in_item);
        end
    end

endmodule

[tb/sliding_window_statistics_top_tb.sv]
// Testbench top for the sliding window statistics block: drives items and register
// writes, stalls the result side, and gives the verdict. Depends on swstat_pkg,
// sliding_window_statistics_top and sliding_window_statistics_checker.
`timescale 1ns / 100ps

module sliding_window_statistics_top_tb;
    import swstat_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 10000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    errors;
    bit                    hold_req;
    int                    burst_left;

    sliding_window_statistics_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sliding_window_statistics_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one item; gaps fall between bursts
    task automatic send(input logic act, input logic [SAMPLE_W-1:0] smp);
        in_item_t it;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                if ($urandom_range(0, 2) != 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
            end
            burst_left--;
            it.action = act;
            it.sample = smp;
            in_valid <= 1'b1;
            in_item  <= it;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic push(input logic [SAMPLE_W-1:0] smp);
        send(ACT_PUSH, smp);
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // window length with random spare upper bits
    task automatic set_len(input logic [CNT_W-1:0] len);
        write_reg(CFG_WINDOW_LENGTH, {6'($urandom), len});
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 7)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    // result side stall pattern, with one long hold-off on request
    initial begin
        int pct;
        bit hold_done;
        out_stall = 1'b0;
        pct = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case ($urandom_range(0, 2))
                0: pct = 0;
                1: pct = 30;
                default: pct = 70;
            endcase
            repeat ($urandom_range(16, 96)) begin
                out_stall <= ($urandom_range(0, 99) < pct);
                @(posedge clk);
            end
        end
    end

    // idle watchdog
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int grp;
        int n;
        int r;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty clear, extremes at reset settings
        send(ACT_CLEAR, 32'hFFFF_FFFF);
        push(32'h7FFF_FFFF);
        push(32'h8000_0000);
        push(32'h0000_0000);
        push(32'hFFFF_FFFF);
        push(32'h0000_0001);
        push(32'h0001_2345);
        drain();
        // shrink without clear, lowest ratio
        set_len(11'd3);
        write_reg(CFG_PERCENTILE_RATIO, 17'd0);
        push(32'd5);
        push(-32'sd5);
        drain();
        write_reg(CFG_PERCENTILE_RATIO, RATIO_ONE);
        push(32'd9);
        push(32'd2);
        drain();
        // ratio above one
        write_reg(CFG_PERCENTILE_RATIO, 17'h1FFFF);
        push(32'd3);
        drain();
        // zero length acts as one
        set_len(11'd0);
        push(32'd4);
        push(32'd6);
        drain();
        // length above the store size
        set_len(11'h7FF);
        write_reg(CFG_PERCENTILE_RATIO, 17'd21845);
        push(32'hFFFF_0000);
        push(32'h0000_8000);
        send(ACT_CLEAR, 32'h1234_5678);
        push(32'h8000_0001);
        drain();

        // random groups, mostly short windows
        for (grp = 0; grp < 12; grp++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                set_len(11'd0);
            else if (r == 1)
                set_len(LEN_RESET);
            else if (r == 2)
                set_len(11'h7FF);
            else
                set_len(11'($urandom_range(1, 16)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_PERCENTILE_RATIO, 17'd0);
                1: write_reg(CFG_PERCENTILE_RATIO, RATIO_ONE);
                2: write_reg(CFG_PERCENTILE_RATIO, 17'($urandom_range(65537, 131071)));
                default: write_reg(CFG_PERCENTILE_RATIO, 17'($urandom_range(0, 65536)));
            endcase
            if (grp == 3)
                hold_req = 1'b1;
            if ($urandom_range(0, 1) != 0)
                send(ACT_CLEAR, $urandom);
            n = $urandom_range(7, 13);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    send(ACT_CLEAR, $urandom);
                else
                    push(rand_sample());
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/swstat_pkg.sv
hdl/swstat_div.sv
hdl/swstat_core.sv
hdl/sliding_window_statistics_top.sv
tb/sliding_window_statistics_checker.sv
tb/sliding_window_statistics_top_tb.sv
